// ===== src/eeg_pkg.sv =====
// Shared types for the extended Euclid block: the command and status bundles
// passed between the sequencer and the shared division unit. No dependencies.
`timescale 1ns / 1ps

package eeg_pkg;

	// Sequencer to division unit: start a division and say how to sign the results
	typedef struct packed {
		logic start;
		logic rem_neg;
		logic quot_neg;
	} div_cmd_t;

	// Division unit to sequencer: results are ready for this cycle's update
	typedef struct packed {
		logic done;
	} div_stat_t;

endpackage

// ===== src/eeg_div_unit.sv =====
// Shared bit-serial divider with coefficient accumulation: one quotient bit a cycle,
// folding q*x and q*y in as the bits appear. Depends on eeg_pkg.
`timescale 1ns / 1ps

module eeg_div_unit import eeg_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  div_cmd_t         cmd,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor_mag,
	input  logic [WIDTH-1:0] coef_x,
	input  logic [WIDTH-1:0] coef_y,
	input  logic [WIDTH-1:0] last_x,
	input  logic [WIDTH-1:0] last_y,
	output div_stat_t        stat,
	output logic [WIDTH-1:0] rem_next,
	output logic [WIDTH-1:0] x_next,
	output logic [WIDTH-1:0] y_next
);

	localparam int CW = $clog2(WIDTH);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] num_q;
	logic [WIDTH-1:0] px_q;
	logic [WIDTH-1:0] py_q;
	logic          rem_neg_q;
	logic          quot_neg_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             qbit;
	logic [WIDTH-1:0] rem_d;
	logic [WIDTH-1:0] px_d;
	logic [WIDTH-1:0] py_d;

	// Restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, num_q[WIDTH-1]};
		diff  = trial - {1'b0, divisor_mag};
		qbit  = ~diff[WIDTH];
		rem_d = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
		px_d  = {px_q[WIDTH-2:0], 1'b0} + (qbit ? coef_x : '0);
		py_d  = {py_q[WIDTH-2:0], 1'b0} + (qbit ? coef_y : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q      <= '0;
			num_q      <= dividend;
			px_q       <= '0;
			py_q       <= '0;
			rem_neg_q  <= cmd.rem_neg;
			quot_neg_q <= cmd.quot_neg;
		end else if (busy_q) begin
			rem_q <= rem_d;
			num_q <= {num_q[WIDTH-2:0], 1'b0};
			px_q  <= px_d;
			py_q  <= py_d;
		end
	end

	// Sign the remainder after the dividend; q*c is subtracted, so a negative q adds
	assign rem_next  = rem_neg_q ? (WIDTH'(0) - rem_q) : rem_q;
	assign x_next    = quot_neg_q ? (last_x + px_q) : (last_x - px_q);
	assign y_next    = quot_neg_q ? (last_y + py_q) : (last_y - py_q);
	assign stat.done = done_q;

endmodule

// ===== src/extended_euclid_gcd.sv =====
// Top level of the extended Euclid block: handshakes, sequencer and the
// remainder and coefficient registers. Depends on eeg_pkg and eeg_div_unit.
`timescale 1ns / 1ps

// Usage
//   Input channel s_*: one item carries a_value and b_value. s_tready is high only
//   while the block is idle; an item is taken when s_tvalid and s_tready are high.
//   Output channel m_*: one item per input, carrying coef_x, coef_y and divisor with
//   a_value*coef_x + b_value*coef_y == divisor (two's complement, WIDTH bits).
// Operation
//   Each Euclid iteration runs a check state, then the shared bit-serial divider (one
//   quotient bit a cycle), then an update step once the divider reports done.
//   After the last iteration of the item taken, the result is loaded and s_tready
//   rises with it; 32-bit operands need at most about 46 iterations.
//   One item is in work at a time; s_tready stays low until the sequencer is idle.
// Stalls
//   The result sits in an output register. A new item is accepted while it still
//   waits; if the next result is ready first, the sequencer holds until m_tready.
// Reset
//   arst_n clears the sequencer to idle and drops m_tvalid; no clearing pass.

module extended_euclid_gcd import eeg_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a_value [WIDTH-1:0], b_value [2*WIDTH-1:WIDTH], zero fill to whole bytes
	input  logic [((2*WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// coef_x [WIDTH-1:0], coef_y [2*WIDTH-1:WIDTH], divisor [3*WIDTH-1:2*WIDTH],
	// zero fill to whole bytes
	output logic [((3*WIDTH+7)/8)*8-1:0] m_tdata
);

	localparam int OUT_W = ((3*WIDTH+7)/8)*8;
	localparam int PAD_W = OUT_W - 3*WIDTH;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	logic [WIDTH-1:0] r0_q, r1_q;
	logic [WIDTH-1:0] x_q, lastx_q;
	logic [WIDTH-1:0] y_q, lasty_q;
	logic [WIDTH-1:0] out_x_q, out_y_q, out_g_q;
	logic             m_valid_q;

	logic [WIDTH-1:0] mag0, mag1;
	logic [WIDTH-1:0] rem_next, x_next, y_next;
	div_cmd_t         cmd;
	div_stat_t        stat;
	logic             in_take;
	logic             out_free;
	logic             out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign in_take  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign out_load = (state_q == ST_FINISH) && out_free;

	// Divide magnitudes; the divider puts the signs back
	assign mag0 = r0_q[WIDTH-1] ? (WIDTH'(0) - r0_q) : r0_q;
	assign mag1 = r1_q[WIDTH-1] ? (WIDTH'(0) - r1_q) : r1_q;

	always_comb begin
		cmd.start    = (state_q == ST_CHECK) && (r1_q != '0);
		cmd.rem_neg  = r0_q[WIDTH-1];
		cmd.quot_neg = r0_q[WIDTH-1] ^ r1_q[WIDTH-1];
	end

	eeg_div_unit #(
		.WIDTH(WIDTH)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dividend   (mag0),
		.divisor_mag(mag1),
		.coef_x     (x_q),
		.coef_y     (y_q),
		.last_x     (lastx_q),
		.last_y     (lasty_q),
		.stat       (stat),
		.rem_next   (rem_next),
		.x_next     (x_next),
		.y_next     (y_next)
	);

	// Sequencer: check for a zero remainder, divide, update, and hand over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			// A new result replaces a taken one; otherwise drop valid once taken
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (r1_q == '0) ? ST_FINISH : ST_DIV;
				end
				ST_DIV: begin
					if (stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers: load the operands, then advance the remainder and coefficient pairs
	always_ff @(posedge clk) begin
		if (in_take) begin
			r0_q    <= s_tdata[WIDTH-1:0];
			r1_q    <= s_tdata[2*WIDTH-1:WIDTH];
			x_q     <= '0;
			lastx_q <= WIDTH'(1);
			y_q     <= WIDTH'(1);
			lasty_q <= '0;
		end else if ((state_q == ST_DIV) && stat.done) begin
			r0_q    <= r1_q;
			r1_q    <= rem_next;
			x_q     <= x_next;
			lastx_q <= x_q;
			y_q     <= y_next;
			lasty_q <= y_q;
		end
	end

	// Output register: hold the result until the receiver takes it
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= lastx_q;
			out_y_q <= lasty_q;
			out_g_q <= r0_q;
		end
	end

	assign m_tvalid = m_valid_q;

	generate
		if (PAD_W > 0) begin : g_pad
			assign m_tdata = {{PAD_W{1'b0}}, out_g_q, out_y_q, out_x_q};
		end else begin : g_nopad
			assign m_tdata = {out_g_q, out_y_q, out_x_q};
		end
	endgenerate

endmodule
